### rtl/ubxp_pkg.sv
`default_nettype none
package ubxp_pkg;

    // frame layout
    localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
    localparam logic [7:0] NAV_CLASS   = 8'h01;
    localparam logic [7:0] PVT_ID      = 8'h07;

    // largest payload that is accepted; longer frames end early
    localparam int unsigned PAYLOAD_MAX = 128;
    localparam int unsigned PVT_MIN_LEN = 92;

    // payload byte offsets of the captured NAV-PVT fields
    localparam logic [7:0] OFS_LON = 8'd24;
    localparam logic [7:0] OFS_LAT = 8'd28;
    localparam logic [7:0] OFS_SPD = 8'd60;
    localparam logic [7:0] OFS_HDG = 8'd64;

    // status codes
    localparam logic [1:0] ST_PVT     = 2'd0;
    localparam logic [1:0] ST_OTHER   = 2'd1;
    localparam logic [1:0] ST_CK_FAIL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // speed: mm/s / 10, saturated at 65535 (reached from 655360 up)
    localparam logic [31:0] SPD_SAT_IN  = 32'd655360;
    localparam logic [15:0] SPD_SAT_OUT = 16'hFFFF;
    localparam logic [19:0] SPD_RECIP   = 20'd838861;   // ceil(2^23 / 10)
    localparam int unsigned SPD_SHIFT   = 23;

    // heading: 1e-5 deg / 10000, saturated at 3600 (reached from 36010000 up)
    localparam logic [31:0] HDG_SAT_IN  = 32'd36010000;
    localparam logic [11:0] HDG_SAT_OUT = 12'd3600;
    localparam logic [25:0] HDG_RECIP   = 26'd54975582; // ceil(2^39 / 10000)
    localparam int unsigned HDG_SHIFT   = 39;

    // queue depth between parser and result stage
    localparam int unsigned QUEUE_DEPTH = 2;

    // one frame-end record from the parser
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  frm_class;
        logic [7:0]  frm_id;
        logic [31:0] lat_raw;
        logic [31:0] lon_raw;
        logic [31:0] spd_raw;
        logic [31:0] hdg_raw;
    } t_frm_rec;

endpackage
`default_nettype wire

### rtl/ubx_nav_pvt_frame_parser.sv
`default_nettype none
// channel | dir | fields (lowest bit first)
// s_axis  | in  | tdata[7:0] rx_byte
// m_axis  | out | tuser[1:0] frame_status; tdata[111:0] frame_class, frame_id,
//         |     | latitude, longitude, ground_speed, heading, 4 zero bits
//
// One byte is taken every cycle while the two-entry record queue has room.
// A frame end passes through the queue write, the multiply stage and the output
// register before it shows on m_axis.
// Reset (synchronous, active low) puts the parser back to the first sync byte
// and empties the queue and the result pipeline.
// A stalled m_axis holds its item; s_axis drops tready only when the queue is full.
module ubx_nav_pvt_frame_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [111:0]        m_axis_tdata,   // class, id, lat, lon, speed, heading
    output logic [1:0]          m_axis_tuser    // [1:0] frame_status
);
    import ubxp_pkg::*;

    t_frm_rec w_push_rec;
    t_frm_rec w_pop_rec;
    logic     w_push;
    logic     w_full;
    logic     w_q_valid;
    logic     w_pop;

    // byte parser
    ubxp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .i_q_full   (w_full),
        .o_byte_rdy (s_axis_tready),
        .o_push     (w_push),
        .o_rec      (w_push_rec)
    );

    // record queue
    ubxp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_rec   (w_pop_rec),
        .i_pop   (w_pop)
    );

    // scaling and output
    ubxp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_rec      (w_pop_rec),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

### rtl/ubxp_front.sv
`default_nettype none
module ubxp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_byte_vld,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_q_full,
    output logic                   o_byte_rdy,
    output logic                   o_push,
    output ubxp_pkg::t_frm_rec     o_rec
);
    import ubxp_pkg::*;

    // parser phases
    localparam logic [3:0] PH_SYNC1 = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_ID    = 4'd3;
    localparam logic [3:0] PH_LEN1  = 4'd4;
    localparam logic [3:0] PH_LEN2  = 4'd5;
    localparam logic [3:0] PH_BODY  = 4'd6;
    localparam logic [3:0] PH_CKA   = 4'd7;
    localparam logic [3:0] PH_CKB   = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [31:0] r_lat, r_lon, r_spd, r_hdg;

    logic        w_acc;
    logic [7:0]  w_acc_a;
    logic [7:0]  w_acc_b;
    logic [15:0] w_len_full;
    logic [8:0]  w_idx_inc;
    logic        w_emit;
    logic [1:0]  w_status;

    // one byte a cycle while the queue has room
    assign o_byte_rdy = !i_q_full;
    assign w_acc      = i_byte_vld && o_byte_rdy;

    // Fletcher-8 running sums
    assign w_acc_a    = r_sum_a + i_byte;
    assign w_acc_b    = r_sum_b + w_acc_a;
    assign w_len_full = {i_byte, r_len[7:0]};
    assign w_idx_inc  = {1'b0, r_idx} + 9'd1;

    // frame tracking
    always_comb begin
        n_phase  = r_phase;
        n_class  = r_class;
        n_id     = r_id;
        n_len    = r_len;
        n_idx    = r_idx;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        w_emit   = 1'b0;
        w_status = ST_OTHER;
        if (w_acc) begin
            case (r_phase)
                PH_SYNC1: begin
                    n_phase = (i_byte == SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
                end
                PH_SYNC2: begin
                    if (i_byte == SYNC_CHAR_2) begin
                        n_phase = PH_CLASS;
                        n_sum_a = 8'd0;
                        n_sum_b = 8'd0;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_CLASS: begin
                    n_class = i_byte;
                    n_sum_a = w_acc_a;
                    n_sum_b = w_acc_b;
                    n_phase = PH_ID;
                end
                PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = w_acc_a;
                    n_sum_b = w_acc_b;
                    n_phase = PH_LEN1;
                end
                PH_LEN1: begin
                    n_len   = {8'd0, i_byte};
                    n_sum_a = w_acc_a;
                    n_sum_b = w_acc_b;
                    n_phase = PH_LEN2;
                end
                PH_LEN2: begin
                    n_len   = w_len_full;
                    n_sum_a = w_acc_a;
                    n_sum_b = w_acc_b;
                    n_idx   = 8'd0;
                    if (w_len_full > 16'(PAYLOAD_MAX)) begin
                        n_phase  = PH_SYNC1;
                        w_emit   = 1'b1;
                        w_status = ST_TOO_LONG;
                    end else if (w_len_full == 16'd0) begin
                        n_phase = PH_CKA;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_sum_a = w_acc_a;
                    n_sum_b = w_acc_b;
                    n_idx   = w_idx_inc[7:0];
                    if ({7'd0, w_idx_inc} >= r_len) begin
                        n_phase = PH_CKA;
                    end
                end
                PH_CKA: begin
                    if (i_byte == r_sum_a) begin
                        n_phase = PH_CKB;
                    end else begin
                        n_phase  = PH_SYNC1;
                        w_emit   = 1'b1;
                        w_status = ST_CK_FAIL;
                    end
                end
                PH_CKB: begin
                    n_phase = PH_SYNC1;
                    w_emit  = 1'b1;
                    if (i_byte != r_sum_b) begin
                        w_status = ST_CK_FAIL;
                    end else if (r_class == NAV_CLASS && r_id == PVT_ID &&
                                 r_len >= 16'(PVT_MIN_LEN)) begin
                        w_status = ST_PVT;
                    end else begin
                        w_status = ST_OTHER;
                    end
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_class <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_idx   <= 8'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    // keep only the payload bytes that feed a PVT result
    always_ff @(posedge i_clk) begin
        if (w_acc && r_phase == PH_BODY) begin
            if (r_idx inside {[OFS_LON : OFS_LON + 8'd3]}) begin
                r_lon[{r_idx[1:0], 3'b000} +: 8] <= i_byte;
            end
            if (r_idx inside {[OFS_LAT : OFS_LAT + 8'd3]}) begin
                r_lat[{r_idx[1:0], 3'b000} +: 8] <= i_byte;
            end
            if (r_idx inside {[OFS_SPD : OFS_SPD + 8'd3]}) begin
                r_spd[{r_idx[1:0], 3'b000} +: 8] <= i_byte;
            end
            if (r_idx inside {[OFS_HDG : OFS_HDG + 8'd3]}) begin
                r_hdg[{r_idx[1:0], 3'b000} +: 8] <= i_byte;
            end
        end
    end

    // frame-end record
    assign o_push            = w_emit;
    assign o_rec.status      = w_status;
    assign o_rec.frm_class   = r_class;
    assign o_rec.frm_id      = r_id;
    assign o_rec.lat_raw     = r_lat;
    assign o_rec.lon_raw     = r_lon;
    assign o_rec.spd_raw     = r_spd;
    assign o_rec.hdg_raw     = r_hdg;

endmodule
`default_nettype wire

### rtl/ubxp_fifo.sv
`default_nettype none
module ubxp_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ubxp_pkg::t_frm_rec i_rec,
    output logic                   o_full,
    output logic                   o_valid,
    output ubxp_pkg::t_frm_rec     o_rec,
    input  wire logic              i_pop
);
    import ubxp_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_frm_rec         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule
`default_nettype wire

### rtl/ubxp_back.sv
`default_nettype none
module ubxp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ubxp_pkg::t_frm_rec i_rec,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [111:0]           o_m_tdata,
    output logic [1:0]             o_m_tuser
);
    import ubxp_pkg::*;

    localparam int unsigned SPD_PW = 40;
    localparam int unsigned HDG_PW = 52;

    // stage 1: scaling products and range flags
    logic              r_s1_v;
    logic [1:0]        r_s1_status;
    logic [7:0]        r_s1_class;
    logic [7:0]        r_s1_id;
    logic [31:0]       r_s1_lat;
    logic [31:0]       r_s1_lon;
    logic              r_s1_spd_pos;
    logic              r_s1_spd_sat;
    logic [SPD_PW-1:0] r_s1_spd_prod;
    logic              r_s1_hdg_pos;
    logic              r_s1_hdg_sat;
    logic [HDG_PW-1:0] r_s1_hdg_prod;

    // stage 2: output register
    logic              r_o_v;
    logic [111:0]      r_o_data;
    logic [1:0]        r_o_user;

    logic              w_adv_o;
    logic              w_load_s1;
    logic              w_pvt;
    logic [15:0]       w_speed;
    logic [11:0]       w_heading;
    logic [31:0]       w_lat;
    logic [31:0]       w_lon;

    assign w_adv_o   = !r_o_v || i_m_tready;
    assign w_load_s1 = !r_s1_v || w_adv_o;
    assign o_pop     = i_valid && w_load_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (w_load_s1) begin
                r_s1_v <= i_valid;
            end
            if (w_adv_o) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    // divide by reciprocal multiply on the clamped range
    always_ff @(posedge i_clk) begin
        if (w_load_s1) begin
            r_s1_status   <= i_rec.status;
            r_s1_class    <= i_rec.frm_class;
            r_s1_id       <= i_rec.frm_id;
            r_s1_lat      <= i_rec.lat_raw;
            r_s1_lon      <= i_rec.lon_raw;
            r_s1_spd_pos  <= !i_rec.spd_raw[31] && (i_rec.spd_raw != 32'd0);
            r_s1_spd_sat  <= i_rec.spd_raw >= SPD_SAT_IN;
            r_s1_spd_prod <= i_rec.spd_raw[19:0] * SPD_RECIP;
            r_s1_hdg_pos  <= !i_rec.hdg_raw[31] && (i_rec.hdg_raw != 32'd0);
            r_s1_hdg_sat  <= i_rec.hdg_raw >= HDG_SAT_IN;
            r_s1_hdg_prod <= i_rec.hdg_raw[25:0] * HDG_RECIP;
        end
    end

    // saturate and clear the fields of non-PVT results
    always_comb begin
        w_pvt     = (r_s1_status == ST_PVT);
        w_speed   = 16'd0;
        w_heading = 12'd0;
        w_lat     = 32'd0;
        w_lon     = 32'd0;
        if (w_pvt) begin
            w_lat = r_s1_lat;
            w_lon = r_s1_lon;
            if (r_s1_spd_pos) begin
                w_speed = r_s1_spd_sat ? SPD_SAT_OUT : r_s1_spd_prod[SPD_SHIFT +: 16];
            end
            if (r_s1_hdg_pos) begin
                w_heading = r_s1_hdg_sat ? HDG_SAT_OUT : r_s1_hdg_prod[HDG_SHIFT +: 12];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_o) begin
            r_o_user <= r_s1_status;
            r_o_data <= {4'd0, w_heading, w_speed, w_lon, w_lat, r_s1_id, r_s1_class};
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

endmodule
`default_nettype wire

### rtl/ubxp_port_chk.sv
`default_nettype none
module ubxp_port_chk (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    input  wire logic           s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,
    input  wire logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    input  wire logic [111:0]   m_axis_tdata,
    input  wire logic [1:0]     m_axis_tuser
);
    import ubxp_pkg::*;

    logic w_in_seen;
    assign w_in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

    // stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // only PVT results carry position and motion fields
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_PVT |-> m_axis_tdata[107:16] == '0)
        else $error("non-PVT result with nonzero fields");

    // heading stays at or below its saturation value, pad bits stay zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[107:96] <= HDG_SAT_OUT &&
                          m_axis_tdata[111:108] == 4'd0)
        else $error("heading out of range or pad bits set");

    // a new result needs an earlier taken byte, unless a result was already valid
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_in_seen, 3) || $past(m_axis_tvalid))
        else $error("result without a preceding byte");

endmodule

bind ubx_nav_pvt_frame_parser ubxp_port_chk u_port_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
